FILE: rtl/detst_pkg.sv
package detst_pkg;

  // Default number of words shared by both stacks
  localparam int unsigned DepthDefault = 8;

  // Field widths
  localparam int unsigned WordWidth = 32;
  localparam int unsigned OpWidth   = 3;
  localparam int unsigned StWidth   = 2;
  localparam int unsigned OccWidth  = 4;

  // Operation codes
  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_LO = 3'd0,
    OP_PUSH_HI = 3'd1,
    OP_POP_LO  = 3'd2,
    OP_POP_HI  = 3'd3,
    OP_PUSH_2  = 3'd4,
    OP_POP_2   = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [StWidth-1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_UNDER = 2'd2
  } stat_e;

endpackage

FILE: rtl/detst_ram.sv
module detst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/double_ended_twin_stack_top.sv
// Single pushes and refused or unused ops finish from idle; a pop reads, then takes the
// word; a double push or pop goes low, then high; the one-write, one-read RAM sets this.
// One item at a time; the next beat may start in the cycle done_o shows.
// Results appear on done_o for one cycle and cannot be stalled by the receiver.
// Reset clears both stack counts and the control state; the word RAM is not cleared.
module double_ended_twin_stack_top #(
  parameter int unsigned DEPTH = detst_pkg::DepthDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [detst_pkg::OpWidth-1:0]          op_i,
  input  logic signed [detst_pkg::WordWidth-1:0] push_value_i,
  output logic                                   done_o,
  output logic signed [detst_pkg::WordWidth-1:0] low_popped_o,
  output logic signed [detst_pkg::WordWidth-1:0] high_popped_o,
  output logic [detst_pkg::StWidth-1:0]          status_o,
  output logic [detst_pkg::OccWidth-1:0]         occupancy_o
);
  import detst_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned UW = CW + 1;
  localparam int unsigned SW = (UW > OccWidth) ? UW : OccWidth;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WR_HI = 4'b0010,
    ST_RD_LO = 4'b0100,
    ST_RD_HI = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        low_q, low_d;
  logic [CW-1:0]        high_q, high_d;
  logic                 dbl_q, dbl_d;
  logic                 done_q, done_d;
  logic [WordWidth-1:0] val_q, val_d;
  logic [WordWidth-1:0] lp_q, lp_d;
  logic [WordWidth-1:0] hp_q, hp_d;
  stat_e                st_q, st_d;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [WordWidth-1:0] wdata, rdata;

  logic [UW-1:0]        used;
  logic                 room1, room2;
  logic [AW-1:0]        lo_wr_addr, hi_wr_addr, lo_rd_addr, hi_rd_addr;
  logic [CW-1:0]        lo_dec, hi_top;
  logic [SW-1:0]        occ_sum;

  // Room checks against the shared store
  assign used  = UW'(low_q) + UW'(high_q);
  assign room1 = used < UW'(DEPTH);
  assign room2 = (used + UW'(2)) <= UW'(DEPTH);

  // Entry addresses for each stack top
  assign lo_dec     = low_q - CW'(1);
  assign hi_top     = CW'(DEPTH) - high_q;
  assign lo_wr_addr = low_q[AW-1:0];
  assign hi_wr_addr = AW'(DEPTH - 1) - high_q[AW-1:0];
  assign lo_rd_addr = lo_dec[AW-1:0];
  assign hi_rd_addr = hi_top[AW-1:0];

  // Sequence each operation over the RAM ports
  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    high_d  = high_q;
    dbl_d   = dbl_q;
    done_d  = 1'b0;
    val_d   = val_q;
    lp_d    = lp_q;
    hp_d    = hp_q;
    st_d    = st_q;
    we      = 1'b0;
    waddr   = lo_wr_addr;
    wdata   = push_value_i;
    re      = 1'b0;
    raddr   = lo_rd_addr;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          lp_d  = '0;
          hp_d  = '0;
          st_d  = STAT_OK;
          val_d = push_value_i;
          dbl_d = 1'b0;
          unique case (op_e'(op_i))
            OP_PUSH_LO: begin
              done_d = 1'b1;
              if (!room1) begin
                st_d = STAT_OVER;
              end else begin
                we    = 1'b1;
                waddr = lo_wr_addr;
                low_d = low_q + CW'(1);
              end
            end
            OP_PUSH_HI: begin
              done_d = 1'b1;
              if (!room1) begin
                st_d = STAT_OVER;
              end else begin
                we     = 1'b1;
                waddr  = hi_wr_addr;
                high_d = high_q + CW'(1);
              end
            end
            OP_PUSH_2: begin
              if (!room2) begin
                st_d   = STAT_OVER;
                done_d = 1'b1;
              end else begin
                we      = 1'b1;
                waddr   = lo_wr_addr;
                low_d   = low_q + CW'(1);
                state_d = ST_WR_HI;
              end
            end
            OP_POP_LO: begin
              if (low_q == '0) begin
                st_d   = STAT_UNDER;
                done_d = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = lo_rd_addr;
                low_d   = lo_dec;
                state_d = ST_RD_LO;
              end
            end
            OP_POP_HI: begin
              if (high_q == '0) begin
                st_d   = STAT_UNDER;
                done_d = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = hi_rd_addr;
                high_d  = high_q - CW'(1);
                state_d = ST_RD_HI;
              end
            end
            OP_POP_2: begin
              if (low_q == '0 || high_q == '0) begin
                st_d   = STAT_UNDER;
                done_d = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = lo_rd_addr;
                low_d   = lo_dec;
                dbl_d   = 1'b1;
                state_d = ST_RD_LO;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Write the high copy of a double push
      ST_WR_HI: begin
        we      = 1'b1;
        waddr   = hi_wr_addr;
        wdata   = val_q;
        high_d  = high_q + CW'(1);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      // Take the low word; chain the high read for a double pop
      ST_RD_LO: begin
        lp_d = rdata;
        if (dbl_q) begin
          re      = 1'b1;
          raddr   = hi_rd_addr;
          high_d  = high_q - CW'(1);
          state_d = ST_RD_HI;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_RD_HI: begin
        hp_d    = rdata;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      low_q   <= '0;
      high_q  <= '0;
      dbl_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      high_q  <= high_d;
      dbl_q   <= dbl_d;
      done_q  <= done_d;
    end
  end

  // Hold the result and push word
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    lp_q  <= lp_d;
    hp_q  <= hp_d;
    st_q  <= st_d;
  end

  detst_ram #(
    .Width(WordWidth),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Counts are final when the result beat shows
  assign occ_sum = SW'(low_q) + SW'(high_q);

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign low_popped_o  = lp_q;
  assign high_popped_o = hp_q;
  assign status_o      = st_q;
  assign occupancy_o   = occ_sum[OccWidth-1:0];

endmodule
